FILE: sv/ostb_pkg.sv
`default_nettype none
package ostb_pkg;

   localparam int CHANNELS     = 16;
   localparam int CHAN_FIELD_W = 4;
   localparam int MS_W         = 16;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STEP_W = $clog2(CHANNELS + 1);
   localparam int CMP_W  = (STEP_W > CHAN_FIELD_W) ? STEP_W : CHAN_FIELD_W;

   typedef logic [CH_W-1:0]   ch_idx_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [CMP_W-1:0]  cmp_type;
   typedef logic [MS_W-1:0]   ms_type;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_POLL = 2'd1,
      KIND_TICK = 2'd2
   } kind_type;

   typedef struct packed {
      logic       accept;
      logic       load_en;
      logic       poll_en;
      logic       tick_en;
      logic       rd_en;
      ch_idx_type rd_idx;
      logic       wb_en;
      ch_idx_type wb_idx;
   } cmd_type;

   typedef struct packed {
      logic tick_live;
   } status_type;

endpackage
`default_nettype wire

FILE: sv/one_shot_timer_bank_top.sv
// Bank of CHANNELS one-shot millisecond timers. The response to a load or
// poll transaction is registered. The next transaction is taken only when
// the response register is empty or its response is taken in the same
// cycle, so with rsp_ready held high transactions run back to back. A tick
// whose timestamp differs from the previous one starts a sweep: the count
// memory is read one channel per cycle and written back in the cycle after
// the read, and no transaction is accepted until the sweep ends. A tick's
// response (always 0) is issued at once, so a poll after a tick sees the
// completed sweep.
`default_nettype none
module one_shot_timer_bank_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [3:0]  req_channel,
   input  wire logic [15:0] req_load_ms,
   input  wire logic [15:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_fired
);

   ostb_pkg::cmd_type    cmd;
   ostb_pkg::status_type status;

   ostb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ostb_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_channel (req_channel),
      .req_load_ms (req_load_ms),
      .req_now_ms  (req_now_ms),
      .status      (status),
      .rsp_fired   (rsp_fired)
   );

endmodule
`default_nettype wire

FILE: sv/ostb_ctrl.sv
`default_nettype none
module ostb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_kind,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ostb_pkg::status_type status,
   output ostb_pkg::cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   state_type          state_ff, state_in;
   ostb_pkg::step_type step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               is_tick;

   assign is_tick   = (req_kind == ostb_pkg::KIND_TICK);
   // idle, and the output register is free or is being emptied this cycle
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // sweep: read channel step, write back channel step-1, read in the cycle before
   always_comb begin
      cmd.accept  = accept;
      cmd.load_en = accept && (req_kind == ostb_pkg::KIND_LOAD);
      cmd.poll_en = accept && (req_kind == ostb_pkg::KIND_POLL);
      cmd.tick_en = accept && is_tick;
      cmd.rd_en   = (state_ff == ST_SWEEP) &&
                    (step_ff < ostb_pkg::step_type'(ostb_pkg::CHANNELS));
      cmd.rd_idx  = ostb_pkg::ch_idx_type'(step_ff);
      cmd.wb_en   = (state_ff == ST_SWEEP) && (step_ff != '0);
      cmd.wb_idx  = ostb_pkg::ch_idx_type'(step_ff - ostb_pkg::step_type'(1));
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_tick && status.tick_live) begin
               state_in = ST_SWEEP;
               step_in  = '0;
            end
         end
         ST_SWEEP: begin
            if (step_ff == ostb_pkg::step_type'(ostb_pkg::CHANNELS)) begin
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + ostb_pkg::step_type'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ostb_dp.sv
`default_nettype none
module ostb_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ostb_pkg::cmd_type    cmd,
   input  wire logic [3:0]           req_channel,
   input  wire logic [15:0]          req_load_ms,
   input  wire logic [15:0]          req_now_ms,
   output ostb_pkg::status_type      status,
   output logic                      rsp_fired
);

   // remaining counts
   ostb_pkg::ms_type mem [ostb_pkg::CHANNELS];
   ostb_pkg::ms_type rdata_ff;
   logic             rvld_ff;

   logic [ostb_pkg::CHANNELS-1:0] vld_ff, vld_in;
   logic [ostb_pkg::CHANNELS-1:0] exp_ff, exp_in;
   ostb_pkg::ms_type              last_stamp_ff, last_stamp_in;
   ostb_pkg::ms_type              elapsed_ff, elapsed_in;
   logic                          fired_ff, fired_in;

   ostb_pkg::ch_idx_type ch_idx;
   ostb_pkg::ch_idx_type wr_addr;
   ostb_pkg::ms_type     wr_data;
   ostb_pkg::ms_type     count;
   ostb_pkg::ms_type     next_cnt;
   logic                 ch_ok;
   logic                 cnt_live;
   logic                 wr_en;

   assign ch_idx = ostb_pkg::ch_idx_type'(req_channel);
   assign ch_ok  = ostb_pkg::cmp_type'(req_channel) <
                   ostb_pkg::cmp_type'(ostb_pkg::CHANNELS);

   assign elapsed_in       = req_now_ms - last_stamp_ff;
   assign status.tick_live = (elapsed_in != '0);

   // a never-written entry reads as zero
   assign count    = rvld_ff ? rdata_ff : '0;
   assign cnt_live = (count != '0);
   assign next_cnt = (count >= elapsed_ff) ? (count - elapsed_ff) : '0;

   assign wr_en   = (cmd.load_en && ch_ok) || (cmd.wb_en && cnt_live);
   assign wr_addr = cmd.load_en ? ch_idx : cmd.wb_idx;
   assign wr_data = cmd.load_en ? req_load_ms : next_cnt;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.rd_idx];
         rvld_ff  <= vld_ff[cmd.rd_idx];
      end
   end

   always_comb begin
      vld_in        = vld_ff;
      exp_in        = exp_ff;
      last_stamp_in = last_stamp_ff;
      fired_in      = fired_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if ((cmd.load_en || cmd.poll_en) && ch_ok) begin
         exp_in[ch_idx] = 1'b0;
      end
      if (cmd.wb_en && cnt_live && (next_cnt == '0)) begin
         exp_in[cmd.wb_idx] = 1'b1;
      end
      if (cmd.tick_en && status.tick_live) begin
         last_stamp_in = req_now_ms;
      end
      if (cmd.accept) begin
         fired_in = cmd.poll_en && ch_ok && exp_ff[ch_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         exp_ff        <= '0;
         last_stamp_ff <= '0;
      end else begin
         vld_ff        <= vld_in;
         exp_ff        <= exp_in;
         last_stamp_ff <= last_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff <= fired_in;
      if (cmd.tick_en) begin
         elapsed_ff <= elapsed_in;
      end
   end

   assign rsp_fired = fired_ff;

endmodule
`default_nettype wire

FILE: sv/ostb_chk.sv
`default_nettype none
module ostb_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_kind,
   input wire logic [3:0]  req_channel,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_fired
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired))
      else $error("response changed while stalled");

   // never take a transaction when the response register cannot be freed
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("input taken over a pending response");

   // anything but a poll answers 0, on the next cycle
   a_non_poll: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_kind != ostb_pkg::KIND_POLL) |=> rsp_valid && !rsp_fired)
      else $error("non-poll transaction reported fired");

   // a poll right after a load of the same channel cannot have fired
   a_load_poll: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_kind == ostb_pkg::KIND_POLL) &&
      $past(req_acc && (req_kind == ostb_pkg::KIND_LOAD)) &&
      (req_channel == $past(req_channel)) |=> rsp_valid && !rsp_fired)
      else $error("poll after load reported fired");

endmodule

bind one_shot_timer_bank_top ostb_chk u_chk (.*);
`default_nettype wire
